FILE: hdl/ccpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpf_pkg
// Shared widths, request and response codes and the result record of the
// base-relative code cache with partial line fill.
// ----------------------------------------------------------------------------
package ccpf_pkg;

  localparam int CACHE_BYTES_DEF = 512;
  localparam int LINE_BYTES_DEF  = 16;

  localparam int REQ_W   = 3;
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int KIND_W  = 2;
  localparam int BUS_W   = 24;
  localparam int BANK_W  = 7;
  localparam int CIDX_W  = 1;

  // request types
  localparam logic [REQ_W-1:0] REQ_FETCH   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RETURN  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_HOST_RD = 3'd2;
  localparam logic [REQ_W-1:0] REQ_HOST_WR = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FLUSH   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_FINISH  = 3'd5;

  // response kinds
  localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BUS_RD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HOST_RD = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd3;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_CODE_BASE    = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_PROGRAM_BANK = 1'd1;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [BUS_W-1:0]  bus_addr;
    logic [DATA_W-1:0] byte_out;
    logic              last;
  } result_t;

endpackage

FILE: hdl/ccpf_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpf_store
// Code byte store: one write port, one registered read port with forwarding
// of a same-cycle write, and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module ccpf_store
  import ccpf_pkg::*;
#(
  parameter int DEPTH = CACHE_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  output logic [DATA_W-1:0]        rd_data,
  output logic                     clear_done
);

  localparam int AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;
  logic              fwd_r;
  logic [DATA_W-1:0] fwd_data_r;
  logic [AW:0]       clr_cnt_r;
  logic [AW:0]       clr_cnt_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;

  assign clear_done = clr_cnt_r[AW];

  always_comb begin
    clr_cnt_nxt = clear_done ? clr_cnt_r : clr_cnt_r + 1'b1;
    if (!clear_done) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r[AW-1:0];
      mem_wd = '0;
    end else begin
      mem_we = wr_en;
      mem_wa = wr_addr;
      mem_wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  // hold read data for the item in the control stage; a write in the
  // same cycle to the same entry wins over the old contents
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r    <= mem[rd_addr];
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rdata_r;

endmodule

FILE: hdl/ccpf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpf_ctrl
// Control stage: decodes the held request against line valid bits and fill
// state, steps out bus read requests, and updates state when it retires.
// ----------------------------------------------------------------------------
module ccpf_ctrl
  import ccpf_pkg::*;
#(
  parameter int CACHE_BYTES = CACHE_BYTES_DEF,
  parameter int LINE_BYTES  = LINE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [REQ_W-1:0]               req_type,
  input  logic [ADDR_W-1:0]              addr,
  input  logic [DATA_W-1:0]              data,
  input  logic [ADDR_W-1:0]              code_base,
  input  logic [BANK_W-1:0]              program_bank,
  input  logic [DATA_W-1:0]              rd_data,
  input  logic                           slot_free,
  output logic                           stage_free,
  output logic                           wr_en,
  output logic [$clog2(CACHE_BYTES)-1:0] wr_addr,
  output logic [DATA_W-1:0]              wr_data,
  output result_t                        res
);

  localparam int OFS_W     = $clog2(CACHE_BYTES);
  localparam int LN_W      = $clog2(LINE_BYTES);
  localparam int NUM_LINES = CACHE_BYTES / LINE_BYTES;
  localparam int LIDX_W    = OFS_W - LN_W;

  typedef enum logic [1:0] {W_IDLE, W_MISS, W_DIRECT, W_FINISH} wait_t;

  // held request
  logic               s2_valid_r, s2_valid_nxt;
  logic [REQ_W-1:0]   req_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [DATA_W-1:0]  data_r;
  logic [LN_W-1:0]    cnt_r, cnt_nxt;

  // cache state
  logic [NUM_LINES-1:0] line_valid_r, line_valid_nxt;
  logic [OFS_W:0]       fill_pos_r, fill_pos_nxt;
  logic                 flushed_r, flushed_nxt;
  wait_t                wait_r, wait_nxt;
  logic [OFS_W:0]       wp_r, wp_nxt;
  logic [OFS_W-1:0]     tgt_r, tgt_nxt;
  logic [DATA_W-1:0]    tgt_byte_r;

  logic [ADDR_W:0]    diff;
  logic               in_win;
  logic [OFS_W-1:0]   off;
  logic [ADDR_W-1:0]  host_sum;
  logic [OFS_W-1:0]   host_a;
  logic [LN_W-1:0]    nib;
  logic [OFS_W-1:0]   miss_from;
  logic               fin_cond;
  logic [OFS_W-1:0]   fin_from;
  logic [OFS_W-1:0]   fin_tgt;
  logic [OFS_W:0]     wp_inc;
  logic               fill_done;
  logic [DATA_W-1:0]  final_byte;

  logic               one_res;
  logic               do_fill;
  logic               we_c;
  logic [OFS_W-1:0]   wa_c;
  logic [KIND_W-1:0]  r_kind;
  logic [BUS_W-1:0]   r_bus;
  logic [DATA_W-1:0]  r_byte;
  logic [OFS_W-1:0]   fill_from;
  logic [OFS_W-1:0]   fill_tgt;

  logic [OFS_W-1:0]   p;
  logic [ADDR_W-1:0]  p_bus;
  logic               em_last;
  logic               has_res;
  logic               cur_last;
  logic               emit;
  logic               adv;

  always_comb begin
    diff      = {1'b0, addr_r} - {1'b0, code_base};
    in_win    = !diff[ADDR_W] && (diff[ADDR_W-1:0] < ADDR_W'(CACHE_BYTES));
    off       = diff[OFS_W-1:0];
    host_sum  = addr_r + code_base;
    host_a    = host_sum[OFS_W-1:0];
    nib       = flushed_r ? '0 : fill_pos_r[LN_W-1:0];
    miss_from = {off[OFS_W-1:LN_W], nib};
    fin_cond  = !flushed_r && (fill_pos_r[LN_W-1:0] != '0) && !fill_pos_r[OFS_W];
    fin_from  = fill_pos_r[OFS_W-1:0];
    fin_tgt   = {fin_from[OFS_W-1:LN_W], {LN_W{1'b1}}};
    wp_inc    = wp_r + 1'b1;
    fill_done = wp_inc > {1'b0, tgt_r};
    // the last returned byte is the target unless the fill started past it
    final_byte = (wp_r[OFS_W-1:0] == tgt_r) ? data_r : tgt_byte_r;
  end

  // decode the held request
  always_comb begin
    one_res   = 1'b0;
    do_fill   = 1'b0;
    we_c      = 1'b0;
    wa_c      = wp_r[OFS_W-1:0];
    r_kind    = KIND_BYTE;
    r_bus     = '0;
    r_byte    = '0;
    fill_from = miss_from;
    fill_tgt  = off;
    if (wait_r != W_IDLE) begin
      if (req_r == REQ_RETURN) begin
        if (wait_r == W_DIRECT) begin
          one_res = 1'b1;
          r_byte  = data_r;
        end else begin
          we_c = 1'b1;
          if (fill_done) begin
            one_res = 1'b1;
            if (wait_r == W_MISS) begin
              r_byte = final_byte;
            end else begin
              r_kind = KIND_DONE;
            end
          end
        end
      end
    end else begin
      case (req_r)
        REQ_FETCH: begin
          if (!in_win) begin
            one_res = 1'b1;
            r_kind  = KIND_BUS_RD;
            r_bus   = {1'b0, program_bank, addr_r};
          end else if (line_valid_r[off[OFS_W-1:LN_W]]) begin
            one_res = 1'b1;
            r_byte  = rd_data;
          end else begin
            do_fill = 1'b1;
          end
        end
        REQ_HOST_RD: begin
          one_res = 1'b1;
          r_kind  = KIND_HOST_RD;
          r_byte  = rd_data;
        end
        REQ_HOST_WR: begin
          we_c = 1'b1;
          wa_c = host_a;
        end
        REQ_FINISH: begin
          if (fin_cond) begin
            do_fill   = 1'b1;
            fill_from = fin_from;
            fill_tgt  = fin_tgt;
          end else begin
            one_res = 1'b1;
            r_kind  = KIND_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // step through the bus read requests of a fill
  always_comb begin
    p        = fill_from + OFS_W'(cnt_r);
    p_bus    = code_base + ADDR_W'(p);
    em_last  = p >= fill_tgt;
    has_res  = one_res || do_fill;
    cur_last = one_res || em_last;
    emit     = s2_valid_r && has_res && slot_free;
    adv      = s2_valid_r && (!has_res || (slot_free && cur_last));
    stage_free = !s2_valid_r || adv;

    res.valid    = emit;
    res.last     = cur_last;
    res.kind     = do_fill ? KIND_BUS_RD : r_kind;
    res.bus_addr = do_fill ? {1'b0, program_bank, p_bus} : r_bus;
    res.byte_out = do_fill ? '0 : r_byte;

    wr_en   = adv && we_c;
    wr_addr = wa_c;
    wr_data = data_r;
  end

  // next state, applied when the held request retires
  always_comb begin
    s2_valid_nxt   = accept ? 1'b1 : (adv ? 1'b0 : s2_valid_r);
    cnt_nxt        = adv ? '0 : (emit ? cnt_r + 1'b1 : cnt_r);
    line_valid_nxt = line_valid_r;
    fill_pos_nxt   = fill_pos_r;
    flushed_nxt    = flushed_r;
    wait_nxt       = wait_r;
    wp_nxt         = wp_r;
    tgt_nxt        = tgt_r;
    if (adv) begin
      if (wait_r != W_IDLE) begin
        if (req_r == REQ_RETURN) begin
          if (wait_r == W_DIRECT) begin
            wait_nxt = W_IDLE;
          end else begin
            wp_nxt = wp_inc;
            if (fill_done) begin
              fill_pos_nxt = wp_inc;
              wait_nxt     = W_IDLE;
              if (tgt_r[LN_W-1:0] == {LN_W{1'b1}}) begin
                line_valid_nxt[tgt_r[OFS_W-1:LN_W]] = 1'b1;
              end
            end
          end
        end
      end else if (do_fill) begin
        wp_nxt  = {1'b0, fill_from};
        tgt_nxt = fill_tgt;
        if (req_r == REQ_FETCH) begin
          wait_nxt     = W_MISS;
          flushed_nxt  = 1'b0;
          fill_pos_nxt = {1'b0, fill_from};
        end else begin
          wait_nxt = W_FINISH;
        end
      end else begin
        case (req_r)
          REQ_FETCH: begin
            if (!in_win) begin
              wait_nxt = W_DIRECT;
            end
          end
          REQ_HOST_WR: begin
            if (host_a[LN_W-1:0] == {LN_W{1'b1}}) begin
              line_valid_nxt[host_a[OFS_W-1:LN_W]] = 1'b1;
            end
          end
          REQ_FLUSH: begin
            flushed_nxt    = 1'b1;
            fill_pos_nxt   = '0;
            line_valid_nxt = '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r   <= 1'b0;
      cnt_r        <= '0;
      line_valid_r <= '0;
      fill_pos_r   <= '0;
      flushed_r    <= 1'b1;
      wait_r       <= W_IDLE;
      wp_r         <= '0;
      tgt_r        <= '0;
    end else begin
      s2_valid_r   <= s2_valid_nxt;
      cnt_r        <= cnt_nxt;
      line_valid_r <= line_valid_nxt;
      fill_pos_r   <= fill_pos_nxt;
      flushed_r    <= flushed_nxt;
      wait_r       <= wait_nxt;
      wp_r         <= wp_nxt;
      tgt_r        <= tgt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= req_type;
      addr_r <= addr;
      data_r <= data;
    end
    // keep the stored byte at the miss target for a fill that starts past it
    if (adv && do_fill) begin
      tgt_byte_r <= rd_data;
    end
  end

`ifndef SYNTH
  a_fill_not_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    (wait_r == W_MISS || wait_r == W_FINISH) |-> !flushed_r)
    else $error("fill outstanding while flushed mark set");

  a_wp_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    (wait_r == W_MISS || wait_r == W_FINISH) |->
      (!wp_r[OFS_W] && (wp_r[OFS_W-1:LN_W] == tgt_r[OFS_W-1:LN_W])))
    else $error("write pointer left the target line during a fill");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && wait_r == W_IDLE && req_r == REQ_FLUSH) |=>
      (line_valid_r == '0 && flushed_r))
    else $error("flush left a valid line");
`endif

endmodule

FILE: hdl/code_cache_partial_line_fill.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code_cache_partial_line_fill
// Base-relative instruction cache with partial line fill: fetch, bus data
// return, host read/write, flush and finish over streaming channels.
// ----------------------------------------------------------------------------
//
//  channel | ports                      | moves
//  --------+----------------------------+-------------------------------------
//  in      | in_tvalid/tready/tdata/tuser | one request (fetch, return, ...)
//  out     | out_tvalid/tready/tdata/tuser/tlast | one result
//  cfg     | cfg_valid/ready/index/data | one register write
//
//  A fetch hit or host read sustains one per cycle while the out channel
//  is not stalled; the store's single registered read port sets that pace.
//  While out is not stalled, a miss emits one bus read request per cycle (up
//  to LINE_BYTES); each returned byte then comes back as a return request.
//  After reset the store is zeroed by a sweep over every entry; in_tready
//  stays low during it while cfg writes are still taken.
//  A stalled out channel holds the control stage; one request may still wait
//  in it while the output register holds a result.
//
module code_cache_partial_line_fill
  import ccpf_pkg::*;
#(
  parameter int CACHE_BYTES = CACHE_BYTES_DEF,
  parameter int LINE_BYTES  = LINE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [23:0]        in_tdata,   // addr [15:0], data [23:16]
  input  logic [REQ_W-1:0]   in_tuser,   // req_type [2:0]
  // result channel
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,  // bus_addr [23:0], byte_out [31:24]
  output logic [KIND_W-1:0]  out_tuser,  // resp_kind [1:0]
  output logic               out_tlast,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0]  cfg_data
);

  localparam int OFS_W = $clog2(CACHE_BYTES);

  logic [ADDR_W-1:0] code_base_r;
  logic [BANK_W-1:0] program_bank_r;

  logic [ADDR_W-1:0] in_addr;
  logic [DATA_W-1:0] in_data;
  logic              accept;
  logic              stage_free;
  logic              clear_done;
  logic [ADDR_W-1:0] rd_sum;
  logic [OFS_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              wr_en;
  logic [OFS_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              slot_free;
  result_t           res;

  logic               out_valid_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [BUS_W-1:0]   out_bus_r;
  logic [DATA_W-1:0]  out_byte_r;
  logic               out_last_r;

  assign in_addr = in_tdata[ADDR_W-1:0];
  assign in_data = in_tdata[ADDR_W +: DATA_W];

  // configuration: the user must write only while idle (not enforced here); always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_base_r    <= '0;
      program_bank_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CODE_BASE:    code_base_r    <= cfg_data;
        CFG_PROGRAM_BANK: program_bank_r <= cfg_data[BANK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // take a request when the store sweep is done and the control stage frees
  assign in_tready = clear_done && stage_free;
  assign accept    = in_tvalid && in_tready;

  // fetches read the window offset, host reads the base-relative offset
  always_comb begin
    if (in_tuser == REQ_FETCH) begin
      rd_sum = in_addr - code_base_r;
    end else begin
      rd_sum = in_addr + code_base_r;
    end
    rd_addr = rd_sum[OFS_W-1:0];
  end

  ccpf_store #(
    .DEPTH (CACHE_BYTES)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (accept),
    .rd_addr    (rd_addr),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_data    (rd_data),
    .clear_done (clear_done)
  );

  ccpf_ctrl #(
    .CACHE_BYTES (CACHE_BYTES),
    .LINE_BYTES  (LINE_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .req_type     (in_tuser),
    .addr         (in_addr),
    .data         (in_data),
    .code_base    (code_base_r),
    .program_bank (program_bank_r),
    .rd_data      (rd_data),
    .slot_free    (slot_free),
    .stage_free   (stage_free),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .res          (res)
  );

  // output register: load a new result as the previous one drains
  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res.valid) begin
      out_kind_r <= res.kind;
      out_bus_r  <= res.bus_addr;
      out_byte_r <= res.byte_out;
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_byte_r, out_bus_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
